[rtl/assert_macros.svh]
// Assertion helpers used by the RTL (rexs_back).
// They expect clk and rst_n to be in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/rexs_pkg.sv]
// ----------------------------------------------------------------------------
// rexs_pkg
// Shared types, codes and helpers of the RISC execute step.
// ----------------------------------------------------------------------------
package rexs_pkg;

    localparam int XLEN       = 32;
    localparam int ADDR_W     = 12;
    localparam int REG_W      = 4;
    localparam int OPC_W      = 8;
    localparam int OPX_W      = 5;
    localparam int SHAMT_W    = 5;

    // Instruction memory depth; a power of two, so wrapping is a mask
    localparam int IMEM_DEPTH = 4096;
    localparam logic [ADDR_W-1:0] PC_MASK = ADDR_W'(IMEM_DEPTH - 1);

    // Decoupling queue between front and back
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [OPX_W-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MAC  = 5'd2,
        OP_AND  = 5'd3,
        OP_OR   = 5'd4,
        OP_XOR  = 5'd5,
        OP_SLL  = 5'd6,
        OP_SRA  = 5'd7,
        OP_SRL  = 5'd8,
        OP_BEQ  = 5'd9,
        OP_BNE  = 5'd10,
        OP_BLT  = 5'd11,
        OP_BGT  = 5'd12,
        OP_BLE  = 5'd13,
        OP_BGE  = 5'd14,
        OP_JAL  = 5'd15,
        OP_LW   = 5'd16,
        OP_SW   = 5'd17,
        OP_RETI = 5'd18,
        OP_IN   = 5'd19,
        OP_OUT  = 5'd20,
        OP_HALT = 5'd21
    } op_t;

    typedef enum logic [2:0] {
        ACC_NONE     = 3'd0,
        ACC_MEM_LOAD = 3'd1,
        ACC_MEM_STOR = 3'd2,
        ACC_IO_READ  = 3'd3,
        ACC_IO_WRITE = 3'd4
    } acc_kind_t;

    typedef enum logic [1:0] {
        ST_CONTINUE = 2'd0,
        ST_HALT     = 2'd1,
        ST_ILLEGAL  = 2'd2
    } status_t;

    // Classified request as it waits in the queue
    typedef struct packed {
        op_t               opc;
        logic              illegal;
        logic              take;
        logic [REG_W-1:0]  rd;
        logic [XLEN-1:0]   a;
        logic [XLEN-1:0]   b;
        logic [XLEN-1:0]   c;
        logic [XLEN-1:0]   dv;
        logic [ADDR_W-1:0] ira;
        logic [XLEN-1:0]   prod;
    } qent_t;

    // Result as held in the output register
    typedef struct packed {
        logic              write_enable;
        logic [REG_W-1:0]  write_index;
        logic [XLEN-1:0]   write_value;
        logic [ADDR_W-1:0] next_pc;
        acc_kind_t         access_kind;
        logic [ADDR_W-1:0] access_addr;
        logic [XLEN-1:0]   access_data;
        logic              interrupt_done;
        status_t           status;
    } res_t;

    // Reduce an address to the instruction memory range
    function automatic logic [ADDR_W-1:0] pc_wrap(input logic [ADDR_W-1:0] v);
        return v & PC_MASK;
    endfunction

endpackage

[rtl/rexs_if.sv]
// ----------------------------------------------------------------------------
// rexs_if
// Valid/ready channels of the execute step: instruction in, result out.
// ----------------------------------------------------------------------------
interface rexs_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         op;
    logic [3:0]         dest_index;
    logic signed [31:0] src_a;
    logic signed [31:0] src_b;
    logic signed [31:0] src_c;
    logic signed [31:0] dest_value;
    logic [11:0]        irq_return_addr;

    modport source (
        output valid, op, dest_index, src_a, src_b, src_c, dest_value,
               irq_return_addr,
        input  ready
    );
    modport sink (
        input  valid, op, dest_index, src_a, src_b, src_c, dest_value,
               irq_return_addr,
        output ready
    );
endinterface

interface rexs_out_if;
    logic               valid;
    logic               ready;
    logic               write_enable;
    logic [3:0]         write_index;
    logic signed [31:0] write_value;
    logic [11:0]        next_pc;
    logic [2:0]         access_kind;
    logic [11:0]        access_addr;
    logic signed [31:0] access_data;
    logic               interrupt_done;
    logic [1:0]         status;

    modport source (
        output valid, write_enable, write_index, write_value, next_pc,
               access_kind, access_addr, access_data, interrupt_done, status,
        input  ready
    );
    modport sink (
        input  valid, write_enable, write_index, write_value, next_pc,
               access_kind, access_addr, access_data, interrupt_done, status,
        output ready
    );
endinterface

[rtl/rexs_front.sv]
// ----------------------------------------------------------------------------
// rexs_front
// Accept instruction requests, classify the opcode, resolve the branch
// condition and form the product for multiply-accumulate.
// ----------------------------------------------------------------------------
module rexs_front (
    rexs_in_if.sink          inst,
    output rexs_pkg::qent_t  ent,
    output logic             ent_valid,
    input  logic             ent_ready
);
    import rexs_pkg::*;

    op_t             opc;
    logic            illegal;
    logic            take;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;

    assign a = inst.src_a;
    assign b = inst.src_b;

    // Classify the opcode
    assign illegal = (inst.op > OPC_W'(OP_HALT));
    assign opc     = op_t'(inst.op[OPX_W-1:0]);

    // Resolve the branch condition on signed operands
    always_comb
    begin
        unique case (opc)
            OP_BEQ:  take = (a == b);
            OP_BNE:  take = (a != b);
            OP_BLT:  take = ($signed(a) <  $signed(b));
            OP_BGT:  take = ($signed(a) >  $signed(b));
            OP_BLE:  take = ($signed(a) <= $signed(b));
            OP_BGE:  take = ($signed(a) >= $signed(b));
            OP_JAL:  take = 1'b1;
            default: take = 1'b0;
        endcase
    end

    // Pack the classified request for the queue
    always_comb
    begin
        ent.opc     = opc;
        ent.illegal = illegal;
        ent.take    = take && !illegal;
        ent.rd      = inst.dest_index;
        ent.a       = a;
        ent.b       = b;
        ent.c       = inst.src_c;
        ent.dv      = inst.dest_value;
        ent.ira     = inst.irq_return_addr;
        ent.prod    = a * b;
    end

    // Hand over while the queue has room
    assign ent_valid  = inst.valid;
    assign inst.ready = ent_ready;

endmodule

[rtl/rexs_queue.sv]
// ----------------------------------------------------------------------------
// rexs_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module rexs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  rexs_pkg::qent_t  push_data,
    input  logic             push_valid,
    output logic             push_ready,
    output rexs_pkg::qent_t  pop_data,
    output logic             pop_valid,
    input  logic             pop_ready
);
    import rexs_pkg::*;

    qent_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              push;
    logic              pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                             : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0
                                                             : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/rexs_back.sv]
// ----------------------------------------------------------------------------
// rexs_back
// Execute classified requests against the program counter and hold each
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rexs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rexs_pkg::qent_t  head,
    input  logic             head_valid,
    output logic             head_pop,
    rexs_out_if.source       result
);
    import rexs_pkg::*;

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic              vld_reg, vld_next;
    res_t              res_reg, res_next;

    logic [ADDR_W-1:0] seq;
    logic [ADDR_W-1:0] target;
    logic [XLEN-1:0]   sum2;
    logic [XLEN-1:0]   sum3;
    logic [XLEN-1:0]   diff3;
    logic [SHAMT_W-1:0] shamt;

    logic              out_write;
    logic              out_stop;
    logic              out_no_access;
    logic              out_quiet;

    // Advance when the output register is free or being drained
    assign head_pop = head_valid && (!vld_reg || result.ready);

    assign seq    = pc_wrap(pc_reg + ADDR_W'(1));
    assign target = pc_wrap(head.c[ADDR_W-1:0]);
    assign sum2   = head.a + head.b;
    assign sum3   = sum2 + head.c;
    assign diff3  = head.a - head.b - head.c;
    assign shamt  = head.b[SHAMT_W-1:0];

    // Execute the request at the head of the queue
    always_comb
    begin
        res_next                = '0;
        res_next.next_pc        = head.take ? target : seq;
        res_next.access_kind    = ACC_NONE;
        res_next.status         = ST_CONTINUE;
        if (head.illegal)
        begin
            res_next.status = ST_ILLEGAL;
        end
        else
        begin
            unique case (head.opc)
                OP_ADD:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = sum3;
                end
                OP_SUB:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = diff3;
                end
                OP_MAC:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = head.prod + head.c;
                end
                OP_AND:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = head.a & head.b & head.c;
                end
                OP_OR:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = head.a | head.b | head.c;
                end
                OP_XOR:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = head.a ^ head.b ^ head.c;
                end
                OP_SLL:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = head.a << shamt;
                end
                OP_SRA:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = XLEN'($signed(head.a) >>> shamt);
                end
                OP_SRL:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = head.a >> shamt;
                end
                OP_BEQ, OP_BNE, OP_BLT, OP_BGT, OP_BLE, OP_BGE:
                begin
                    res_next.status = ST_CONTINUE;
                end
                OP_JAL:
                begin
                    res_next.write_enable = 1'b1;
                    res_next.write_value  = XLEN'(seq);
                end
                OP_LW:
                begin
                    res_next.access_kind = ACC_MEM_LOAD;
                    res_next.access_addr = sum3[ADDR_W-1:0];
                end
                OP_SW:
                begin
                    res_next.access_kind = ACC_MEM_STOR;
                    res_next.access_addr = sum2[ADDR_W-1:0];
                    res_next.access_data = head.c + head.dv;
                end
                OP_RETI:
                begin
                    res_next.next_pc        = pc_wrap(head.ira);
                    res_next.interrupt_done = 1'b1;
                end
                OP_IN:
                begin
                    res_next.access_kind = ACC_IO_READ;
                    res_next.access_addr = sum2[ADDR_W-1:0];
                end
                OP_OUT:
                begin
                    res_next.access_kind = ACC_IO_WRITE;
                    res_next.access_addr = sum2[ADDR_W-1:0];
                    res_next.access_data = head.c;
                end
                OP_HALT:
                begin
                    res_next.status = ST_HALT;
                end
                default:
                begin
                    res_next.status = ST_ILLEGAL;
                end
            endcase
            // Writes name their destination; loads and reads name the register that the returned data fills
            if (res_next.write_enable || res_next.access_kind == ACC_MEM_LOAD
                || res_next.access_kind == ACC_IO_READ)
            begin
                res_next.write_index = head.rd;
            end
        end
    end

    // Hold the program counter and output valid
    always_comb
    begin
        pc_next  = pc_reg;
        vld_next = vld_reg;
        if (head_pop)
        begin
            pc_next  = res_next.next_pc;
            vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            pc_reg  <= pc_next;
            vld_reg <= vld_next;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            res_reg <= res_next;
        end
    end

    // Drive the result channel
    assign result.valid          = vld_reg;
    assign result.write_enable   = res_reg.write_enable;
    assign result.write_index    = res_reg.write_index;
    assign result.write_value    = res_reg.write_value;
    assign result.next_pc        = res_reg.next_pc;
    assign result.access_kind    = res_reg.access_kind;
    assign result.access_addr    = res_reg.access_addr;
    assign result.access_data    = res_reg.access_data;
    assign result.interrupt_done = res_reg.interrupt_done;
    assign result.status         = res_reg.status;

    // Shorthands for the held result
    assign out_write     = vld_reg && res_reg.write_enable;
    assign out_stop      = vld_reg && res_reg.status != ST_CONTINUE;
    assign out_no_access = (res_reg.access_kind == ACC_NONE);
    assign out_quiet     = out_no_access && !res_reg.write_enable && !res_reg.interrupt_done;

    `ASSERT_NEXT(a_pc_tracks_result, head_pop, pc_reg == res_reg.next_pc)
    `ASSERT_IMP(a_write_no_access, out_write, out_no_access)
    `ASSERT_IMP(a_stop_is_quiet, out_stop, out_quiet)

endmodule

[rtl/risc_execute_step.sv]
// A request accepted is registered first in the queue and then in the output register before its result shows.
// Throughput: one request per cycle while the result channel is ready.
// The two-entry queue lets the input keep accepting while a result waits.
// Reset clears the program counter to zero and empties queue and output register.
// ----------------------------------------------------------------------------
// risc_execute_step
// Execute stage of a three-operand RISC machine: write-back, next pc and
// memory or IO access request for each instruction.
// ----------------------------------------------------------------------------
module risc_execute_step (
    input  logic        clk,
    input  logic        rst_n,
    rexs_in_if.sink     inst,
    rexs_out_if.source  result
);
    import rexs_pkg::*;

    qent_t front_ent;
    logic  front_valid;
    logic  front_ready;
    qent_t head_ent;
    logic  head_valid;
    logic  head_pop;

    // Classify incoming requests
    rexs_front u_front (
        .inst      (inst),
        .ent       (front_ent),
        .ent_valid (front_valid),
        .ent_ready (front_ready)
    );

    // Decouple front and back
    rexs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_ent),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (head_ent),
        .pop_valid  (head_valid),
        .pop_ready  (head_pop)
    );

    // Execute and register results
    rexs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_ent),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .result     (result)
    );

endmodule
